// ===== design/sbe_pkg.sv =====
package sbe_pkg;

   localparam int StackDepth = 256;
   localparam int SpWidth    = $clog2(StackDepth + 1);
   localparam int AddrWidth  = $clog2(StackDepth);
   localparam int PcWidth    = 16;
   localparam int EntryWidth = 34;

   typedef enum logic [1:0] {
      TY_NULL = 2'd0,
      TY_BOOL = 2'd1,
      TY_INT  = 2'd2
   } vtype_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_RET   = 3'd1,
      ST_OVF   = 3'd2,
      ST_BADOP = 3'd3,
      ST_DIV0  = 3'd4,
      ST_UNDER = 3'd5
   } status_type;

   localparam logic [7:0] OP_PUSH  = 8'd0;
   localparam logic [7:0] OP_NULL  = 8'd1;
   localparam logic [7:0] OP_TRUE  = 8'd2;
   localparam logic [7:0] OP_FALSE = 8'd3;
   localparam logic [7:0] OP_POP   = 8'd4;
   localparam logic [7:0] OP_ADD   = 8'd5;
   localparam logic [7:0] OP_SUB   = 8'd6;
   localparam logic [7:0] OP_MUL   = 8'd7;
   localparam logic [7:0] OP_DIV   = 8'd8;
   localparam logic [7:0] OP_NEG   = 8'd9;
   localparam logic [7:0] OP_LT    = 8'd10;
   localparam logic [7:0] OP_LE    = 8'd11;
   localparam logic [7:0] OP_GT    = 8'd12;
   localparam logic [7:0] OP_GE    = 8'd13;
   localparam logic [7:0] OP_NOT   = 8'd14;
   localparam logic [7:0] OP_JF    = 8'd15;
   localparam logic [7:0] OP_JUMP  = 8'd16;
   localparam logic [7:0] OP_LOOP  = 8'd17;
   localparam logic [7:0] OP_RET   = 8'd18;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_DIV,
      S_OUT
   } state_type;

endpackage

// ===== design/stack_bytecode_executor.sv =====
// Stack bytecode executor.
// The req_ channel takes one decoded instruction per beat: opcode and
// immediate. The block keeps a typed value stack and a program counter and
// answers each instruction with exactly one rsp_ beat giving the next
// program counter, a status, the top of stack (or the value returned) and
// the stack depth afterward.
// The stack lives in one synchronous RAM. An instruction takes a stack
// read of its operands (two reads for binary operations, pop and return
// with two or more entries), an execute step that writes any result back,
// then the result beat; divide also waits on its bit-serial divider. A new
// instruction can be accepted from the cycle after the result beat has
// been taken.
// Reset clears the stack pointer and program counter; the stack RAM is
// not cleared, since only entries below the stack pointer are read.
// If the receiver holds rsp_tready low, the result is kept stable and no
// new instruction is accepted.
module stack_bytecode_executor
   import sbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // op[7:0], immediate[39:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // next_pc[15:0], status[18:16],
                                    // result_value[50:19], result_type[52:51],
                                    // stack_depth[61:53]
);

   state_type state_ff, state_in;

   logic [7:0]           op_ff;
   logic [31:0]          imm_ff;
   logic [SpWidth-1:0]   sp_ff, sp_in;
   logic [PcWidth-1:0]   pc_ff, pc_in;
   logic [EntryWidth-1:0] b_ff;
   logic                 rd_step_ff, rd_step_in;

   logic [PcWidth-1:0]   o_pc_ff, o_pc_in;
   status_type           o_st_ff, o_st_in;
   logic [31:0]          o_val_ff, o_val_in;
   logic [1:0]           o_ty_ff, o_ty_in;
   logic [SpWidth-1:0]   o_sp_ff, o_sp_in;
   // Cached top of stack, so the result needs no extra read.
   logic [EntryWidth-1:0] top_ff, top_in;

   logic                 wr_en;
   logic [AddrWidth-1:0] wr_addr, rd_addr;
   logic [EntryWidth-1:0] wr_data, rd_data;
   logic                 div_start, div_done;
   logic [31:0]          div_q;
   logic [31:0]          mul_r;

   logic is_push, is_unary, is_binary, is_drop, two_read;
   logic [15:0] off;

   assign is_push   = op_ff <= OP_FALSE;
   assign is_unary  = op_ff == OP_POP || op_ff == OP_NEG || op_ff == OP_NOT ||
                      op_ff == OP_JF || op_ff == OP_RET;
   assign is_binary = op_ff >= OP_ADD && op_ff <= OP_GE && op_ff != OP_NEG;
   assign is_drop   = op_ff == OP_POP || op_ff == OP_RET;
   assign two_read  = (is_binary || is_drop) && sp_ff >= SpWidth'(2);
   assign off       = imm_ff[15:0];

   sbe_ram #(.Width(EntryWidth), .Depth(StackDepth)) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   sbe_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(rd_data[31:0]),
      .divisor (b_ff[31:0]),
      .done    (div_done),
      .quotient(div_q)
   );

   assign mul_r = rd_data[31:0] * b_ff[31:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_READ;
         S_READ: begin
            if (two_read && !rd_step_ff) state_in = S_READ;
            else state_in = S_EXEC;
         end
         S_EXEC: begin
            if (is_binary && sp_ff >= SpWidth'(2) && op_ff == OP_DIV &&
                b_ff[31:0] != 32'd0) state_in = S_DIV;
            else state_in = S_OUT;
         end
         S_DIV:  if (div_done) state_in = S_OUT;
         S_OUT:  if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      logic [EntryWidth-1:0] a;
      logic [31:0] diff;
      logic falsey;
      logic cmp;
      a          = rd_data;
      diff       = rd_data[31:0] - b_ff[31:0];
      falsey     = rd_data[33:32] == TY_NULL ||
                   (rd_data[33:32] == TY_BOOL && rd_data[31:0] == 32'd0);
      cmp        = 1'b0;
      sp_in      = sp_ff;
      pc_in      = pc_ff;
      top_in     = top_ff;
      rd_step_in = 1'b0;
      o_pc_in    = o_pc_ff;
      o_st_in    = o_st_ff;
      o_val_in   = o_val_ff;
      o_ty_in    = o_ty_ff;
      o_sp_in    = o_sp_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      rd_addr    = AddrWidth'(sp_ff - SpWidth'(1));
      div_start  = 1'b0;
      req_tready = state_ff == S_IDLE;

      unique case (state_ff)
         S_READ: begin
            // Two reads: the first cycle holds the top at sp-1, and the
            // entry at sp-2 arrives for the execute cycle.
            if (two_read) begin
               rd_step_in = !rd_step_ff;
               rd_addr    = AddrWidth'(sp_ff - SpWidth'(2));
            end
         end
         S_EXEC: begin
            o_st_in = ST_OK;
            unique case (1'b1)
               is_push: begin
                  if (sp_ff >= SpWidth'(StackDepth)) begin
                     o_st_in = ST_OVF;
                  end else begin
                     case (op_ff)
                        OP_PUSH: a = {TY_INT, imm_ff};
                        OP_NULL: a = {TY_NULL, 32'd0};
                        OP_TRUE: a = {TY_BOOL, 32'd1};
                        default: a = {TY_BOOL, 32'd0};
                     endcase
                     wr_en   = 1'b1;
                     wr_addr = AddrWidth'(sp_ff);
                     wr_data = a;
                     top_in  = a;
                     sp_in   = sp_ff + SpWidth'(1);
                     pc_in   = pc_ff + ((op_ff == OP_PUSH) ? PcWidth'(5) : PcWidth'(1));
                  end
               end
               is_unary: begin
                  if (sp_ff == '0) begin
                     o_st_in = ST_UNDER;
                  end else begin
                     pc_in = pc_ff + PcWidth'(1);
                     case (op_ff)
                        OP_POP: begin
                           sp_in = sp_ff - SpWidth'(1);
                           if (two_read) top_in = rd_data;
                        end
                        OP_NEG: begin
                           a       = {rd_data[33:32], 32'd0 - rd_data[31:0]};
                           wr_en   = 1'b1;
                           wr_addr = AddrWidth'(sp_ff - SpWidth'(1));
                           wr_data = a;
                           top_in  = a;
                        end
                        OP_NOT: begin
                           a       = {TY_BOOL, 31'd0, falsey};
                           wr_en   = 1'b1;
                           wr_addr = AddrWidth'(sp_ff - SpWidth'(1));
                           wr_data = a;
                           top_in  = a;
                        end
                        OP_JF: begin
                           pc_in = pc_ff + PcWidth'(3) +
                                   (falsey ? PcWidth'(off) : PcWidth'(0));
                        end
                        default: begin
                           o_st_in = ST_RET;
                           sp_in   = sp_ff - SpWidth'(1);
                           if (two_read) top_in = rd_data;
                        end
                     endcase
                  end
               end
               is_binary: begin
                  if (sp_ff < SpWidth'(2)) begin
                     o_st_in = ST_UNDER;
                  end else if (op_ff == OP_DIV && b_ff[31:0] == 32'd0) begin
                     o_st_in = ST_DIV0;
                  end else if (op_ff == OP_DIV) begin
                     div_start = 1'b1;
                  end else begin
                     case (op_ff)
                        OP_LT: cmp = diff[31];
                        OP_LE: cmp = diff[31] || diff == 32'd0;
                        OP_GT: cmp = !diff[31] && diff != 32'd0;
                        default: cmp = !diff[31];
                     endcase
                     case (op_ff)
                        OP_ADD: a = {TY_INT, rd_data[31:0] + b_ff[31:0]};
                        OP_SUB: a = {TY_INT, diff};
                        OP_MUL: a = {TY_INT, mul_r};
                        default: a = {TY_BOOL, 31'd0, cmp};
                     endcase
                     wr_en   = 1'b1;
                     wr_addr = AddrWidth'(sp_ff - SpWidth'(2));
                     wr_data = a;
                     top_in  = a;
                     sp_in   = sp_ff - SpWidth'(1);
                     pc_in   = pc_ff + PcWidth'(1);
                  end
               end
               default: begin
                  if (op_ff == OP_JUMP) begin
                     pc_in = pc_ff + PcWidth'(3) + PcWidth'(off);
                  end else if (op_ff == OP_LOOP) begin
                     pc_in = pc_ff + PcWidth'(3) - PcWidth'(off);
                  end else begin
                     o_st_in = ST_BADOP;
                  end
               end
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               a       = {TY_INT, div_q};
               wr_en   = 1'b1;
               wr_addr = AddrWidth'(sp_ff - SpWidth'(2));
               wr_data = a;
               top_in  = a;
               sp_in   = sp_ff - SpWidth'(1);
               pc_in   = pc_ff + PcWidth'(1);
            end
         end
         default: begin
         end
      endcase

      // Result fields are settled in the cycle that enters S_OUT.
      if (state_in == S_OUT && state_ff != S_OUT) begin
         o_pc_in = pc_in;
         o_sp_in = sp_in;
         if (state_ff == S_EXEC && o_st_in == ST_RET) begin
            o_val_in = b_ff[31:0];
            o_ty_in  = b_ff[33:32];
         end else if (sp_in == '0) begin
            o_val_in = 32'd0;
            o_ty_in  = TY_NULL;
         end else begin
            o_val_in = top_in[31:0];
            o_ty_in  = top_in[33:32];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         sp_ff      <= '0;
         pc_ff      <= '0;
         rd_step_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sp_ff      <= sp_in;
         pc_ff      <= pc_in;
         rd_step_ff <= rd_step_in;
      end
      if (state_ff == S_IDLE && req_tvalid) begin
         op_ff  <= req_tdata[7:0];
         imm_ff <= req_tdata[39:8];
      end
      if (state_ff == S_READ && !rd_step_ff) b_ff <= rd_data;
      top_ff   <= top_in;
      o_pc_ff  <= o_pc_in;
      o_st_ff  <= o_st_in;
      o_val_ff <= o_val_in;
      o_ty_ff  <= o_ty_in;
      o_sp_ff  <= o_sp_in;
   end

   assign rsp_tvalid = state_ff == S_OUT;
   assign rsp_tdata  = {2'b00, o_sp_ff, o_ty_ff, o_val_ff, o_st_ff, o_pc_ff};

`ifndef SYNTHESIS
   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SpWidth'(StackDepth)) else $error("stack pointer out of range");
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid) else $error("result repeated");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accepted while result pending");
`endif

endmodule

// ===== design/sbe_ram.sv =====
module sbe_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== design/sbe_div.sv =====
module sbe_div
   import sbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   // Restoring divide on magnitudes, one quotient bit per cycle.
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend[31] ? 32'd0 - dividend : dividend;
         dvs_in  = divisor[31] ? 32'd0 - divisor : divisor;
         neg_in  = dividend[31] ^ divisor[31];
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? 32'd0 - quo_ff : quo_ff;

`ifndef SYNTHESIS
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");
   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != 6'd0) else $error("divider busy with zero count");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider started while busy");
`endif

endmodule

// ===== dv/stack_bytecode_executor_tb.sv =====
`timescale 1ns / 1ps

module stack_bytecode_executor_tb;
   import sbe_pkg::*;

   localparam int RspWidth   = 64;
   localparam int WatchLimit = 3000;
   localparam int LongHold   = 400;

   typedef struct packed {
      logic [15:0]     next_pc;
      status_type      status;
      logic [31:0]     value;
      vtype_type       vtype;
      logic [8:0]      depth;
   } outcome_type;

   class exec_scoreboard;
      vtype_type   slot_type[StackDepth];
      logic [31:0] slot_val[StackDepth];
      int          sp;
      logic [15:0] pc;
      outcome_type pending[$];
      int          errors;

      function new();
         sp = 0;
         pc = '0;
         errors = 0;
      endfunction

      function bit falsey(int idx);
         return slot_type[idx] == TY_NULL || (slot_type[idx] == TY_BOOL && slot_val[idx] == 0);
      endfunction

      function logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
         logic [31:0] ma;
         logic [31:0] mb;
         logic [31:0] q;
         ma = a[31] ? -a : a;
         mb = b[31] ? -b : b;
         q = ma / mb;
         return (a[31] != b[31]) ? -q : q;
      endfunction

      // Works out the result of one accepted instruction and advances the state.
      function void note_input(logic [7:0] op, logic [31:0] imm);
         outcome_type o;
         logic [15:0] off;
         logic [31:0] a;
         logic [31:0] b;
         logic [31:0] r;
         logic [31:0] diff;
         bit          shown;
         off = imm[15:0];
         o.status = ST_OK;
         o.next_pc = pc;
         shown = 0;
         o.value = '0;
         o.vtype = TY_NULL;
         case (op)
            OP_PUSH, OP_NULL, OP_TRUE, OP_FALSE: begin
               if (sp >= StackDepth) begin
                  o.status = ST_OVF;
               end else begin
                  slot_type[sp] = (op == OP_PUSH) ? TY_INT : (op == OP_NULL) ? TY_NULL : TY_BOOL;
                  slot_val[sp] = (op == OP_PUSH) ? imm : (op == OP_TRUE) ? 32'd1 : 32'd0;
                  sp++;
                  o.next_pc = pc + ((op == OP_PUSH) ? 16'd5 : 16'd1);
               end
            end
            OP_POP, OP_NEG, OP_NOT, OP_JF, OP_RET: begin
               if (sp == 0) begin
                  o.status = ST_UNDER;
               end else begin
                  o.next_pc = pc + 16'd1;
                  case (op)
                     OP_POP: sp--;
                     OP_NEG: slot_val[sp-1] = -slot_val[sp-1];
                     OP_NOT: begin
                        slot_val[sp-1] = falsey(sp - 1) ? 32'd1 : 32'd0;
                        slot_type[sp-1] = TY_BOOL;
                     end
                     OP_JF: o.next_pc = pc + 16'd3 + (falsey(sp - 1) ? off : 16'd0);
                     default: begin
                        o.value = slot_val[sp-1];
                        o.vtype = slot_type[sp-1];
                        shown = 1;
                        sp--;
                        o.status = ST_RET;
                     end
                  endcase
               end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_LE, OP_GT, OP_GE: begin
               if (sp < 2) begin
                  o.status = ST_UNDER;
               end else if (op == OP_DIV && slot_val[sp-1] == 0) begin
                  o.status = ST_DIV0;
               end else begin
                  a = slot_val[sp-2];
                  b = slot_val[sp-1];
                  diff = a - b;
                  case (op)
                     OP_ADD: r = a + b;
                     OP_SUB: r = diff;
                     OP_MUL: r = a * b;
                     OP_DIV: r = quotient(a, b);
                     OP_LT:  r = {31'd0, diff[31]};
                     OP_LE:  r = {31'd0, diff[31] || diff == 0};
                     OP_GT:  r = {31'd0, !diff[31] && diff != 0};
                     default: r = {31'd0, !diff[31]};
                  endcase
                  slot_val[sp-2] = r;
                  slot_type[sp-2] = (op <= OP_DIV) ? TY_INT : TY_BOOL;
                  sp--;
                  o.next_pc = pc + 16'd1;
               end
            end
            OP_JUMP: o.next_pc = pc + 16'd3 + off;
            OP_LOOP: o.next_pc = pc + 16'd3 - off;
            default: o.status = ST_BADOP;
         endcase
         pc = o.next_pc;
         if (!shown && sp > 0) begin
            o.value = slot_val[sp-1];
            o.vtype = slot_type[sp-1];
         end
         o.depth = 9'(sp);
         pending.push_back(o);
      endfunction

      function void check_result(logic [RspWidth-1:0] data);
         logic [63:0] w;
         outcome_type e;
         w = 64'(data);
         if (pending.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual %h", $time, data);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (w[15:0] !== e.next_pc) begin
            $display("%0t: next_pc expected %h actual %h", $time, e.next_pc, w[15:0]);
            errors++;
         end
         if (w[18:16] !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, w[18:16]);
            errors++;
         end
         if (w[50:19] !== e.value) begin
            $display("%0t: result_value expected %h actual %h", $time, e.value, w[50:19]);
            errors++;
         end
         if (w[52:51] !== e.vtype) begin
            $display("%0t: result_type expected %0d actual %0d", $time, e.vtype, w[52:51]);
            errors++;
         end
         if (w[61:53] !== e.depth) begin
            $display("%0t: stack_depth expected %0d actual %0d", $time,
                     e.depth, w[61:53]);
            errors++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [39:0]         req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspWidth-1:0] rsp_tdata;

   exec_scoreboard sb = new();
   bit quiet;
   bit hold_request;
   bit beat_seen;
   int idle_cycles;

   stack_bytecode_executor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      beat_seen <= !reset && rsp_tvalid && rsp_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata);
      end
   end

   // Watchdog on cycles with no beat on either channel.
   always @(posedge clock) begin
      if (reset || beat_seen || (req_tvalid && req_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchLimit) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (LongHold) @(posedge clock);
            hold_request = 0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // tvalid stays high after a beat unless an idle burst follows, so the
   // caller drops it after the last item.
   task automatic send(logic [7:0] op, logic [31:0] imm);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {imm, op};
      do @(posedge clock); while (!req_tready);
      sb.note_input(op, imm);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'($urandom_range(0, 9));
         4: return -32'($urandom_range(1, 9));
         default: return $urandom;
      endcase
   endfunction

   task automatic random_instruction();
      int r;
      logic [7:0] op;
      r = $urandom_range(0, 99);
      if (sb.sp < 2 && r < 60) r = 0;
      if (sb.sp > 24 && r < 30) r = 70;
      if (r < 30) begin
         op = 8'($urandom_range(OP_PUSH, OP_FALSE));
      end else if (r < 62) begin
         op = 8'($urandom_range(OP_ADD, OP_GE));
         if (op == OP_NEG) op = OP_SUB;
      end else if (r < 80) begin
         case ($urandom_range(0, 2))
            0: op = OP_POP;
            1: op = OP_NEG;
            default: op = OP_NOT;
         endcase
      end else if (r < 90) begin
         op = 8'($urandom_range(OP_JF, OP_LOOP));
      end else if (r < 94) begin
         op = OP_RET;
      end else if (r < 97) begin
         op = 8'($urandom_range(OP_RET + 1, 255));
      end else begin
         op = 8'($urandom_range(0, 255));
      end
      send(op, (op == OP_PUSH) ? pick_value() : $urandom);
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      quiet = 0;
      hold_request = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: underflow on an empty stack, extremes, all operations but SUB, LE and GT.
      send(OP_POP, 32'h0);
      send(OP_ADD, 32'h0);
      send(OP_RET, 32'h0);
      send(8'hFF, 32'hFFFF_FFFF);
      send(OP_PUSH, 32'h8000_0000);
      send(OP_PUSH, 32'hFFFF_FFFF);
      send(OP_DIV, 32'h0);
      send(OP_PUSH, 32'h0);
      send(OP_DIV, 32'h0);
      send(OP_POP, 32'h0);
      send(OP_MUL, 32'h0);
      send(OP_PUSH, 32'h7FFF_FFFF);
      send(OP_NEG, 32'h0);
      send(OP_LT, 32'h0);
      send(OP_NULL, 32'h0);
      send(OP_JF, 32'h0000_FFFF);
      send(OP_NOT, 32'h0);
      send(OP_JF, 32'h1234_0010);
      send(OP_TRUE, 32'h0);
      send(OP_FALSE, 32'h0);
      send(OP_GE, 32'h0);
      send(OP_JUMP, 32'hFFFF_FFFF);
      send(OP_LOOP, 32'h0000_FFFF);
      send(OP_RET, 32'h0);
      send(8'd19, 32'h0);

      for (int i = 0; i < 460; i++) begin
         if (i == 200) begin
            // Fill the stack to overflow, then drain it.
            for (int k = 0; k <= StackDepth; k++) send(8'($urandom_range(0, 3)), $urandom);
            for (int k = 0; k <= StackDepth; k++) send(OP_POP, $urandom);
         end
         if (i == 100) hold_request = 1;
         if (i == 390) quiet = 1;
         random_instruction();
      end
      req_tvalid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
